// ----- design/tcp_connection_tracker_core_macros.svh -----
// ----------------------------------------------------------------------------
// TCP connection tracker assertion macros
// Shared property shapes for the checker of the connection tracker core.
// ----------------------------------------------------------------------------
`ifndef TCP_CONNECTION_TRACKER_CORE_MACROS_SVH
`define TCP_CONNECTION_TRACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tct_pkg.sv -----
// ----------------------------------------------------------------------------
// TCP connection tracker package
// Types, codes and reset values shared by the tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tct_pkg;

    localparam int CONN_MAX_DEF = 16;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [4:0]  CONN_LIMIT_RST     = 5'd16;
    localparam logic [15:0] ETHERTYPE_IPV4_RST = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP_RST  = 16'h0806;
    localparam logic [7:0]  TCP_PROTOCOL_RST   = 8'd6;
    localparam logic [3:0]  IP_VERSION4        = 4'd4;

    typedef enum logic [2:0] {
        ACT_DROP_ETHERTYPE = 3'd0,
        ACT_ARP_REPLY      = 3'd1,
        ACT_ARP_DROP       = 3'd2,
        ACT_DROP_NOT_TCP   = 3'd3,
        ACT_SYN_ACK        = 3'd4,
        ACT_SEND_DATA      = 3'd5,
        ACT_IGNORE         = 3'd6,
        ACT_TABLE_FULL     = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        PHASE_CLOSED       = 2'd0,
        PHASE_LISTEN       = 2'd1,
        PHASE_SYN_RECEIVED = 2'd2,
        PHASE_ESTABLISHED  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_CONN_LIMIT     = 2'd0,
        REG_ETHERTYPE_IPV4 = 2'd1,
        REG_ETHERTYPE_ARP  = 2'd2,
        REG_TCP_PROTOCOL   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [4:0]  conn_limit;
        logic [15:0] ethertype_ipv4;
        logic [15:0] ethertype_arp;
        logic [7:0]  tcp_protocol;
    } cfg_t;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [15:0] arp_proto_type;
        logic [3:0]  ip_version;
        logic [7:0]  ip_protocol;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [31:0] peer_seq;
        logic [15:0] initial_seq;
    } frame_t;

    typedef struct packed {
        action_t     action;
        logic [3:0]  entry_index;
        logic [15:0] seq_out;
        logic [31:0] ack_out;
    } result_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        phase_t      phase;
        logic [15:0] seq;
    } entry_t;

endpackage

// ----- design/tct_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// TCP connection tracker configuration registers
// APB register file holding the entry limit and the recognized protocol codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tct_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tct_pkg::PADDR_W-1:0] paddr,
    input  logic [tct_pkg::PDATA_W-1:0] pwdata,
    output logic [tct_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output tct_pkg::cfg_t               cfg
);
    import tct_pkg::*;

    cfg_t       cfg_reg;
    cfg_index_t reg_index;
    logic       wr_en;

    assign reg_index = cfg_index_t'(paddr[3:2]);
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conn_limit     <= CONN_LIMIT_RST;
            cfg_reg.ethertype_ipv4 <= ETHERTYPE_IPV4_RST;
            cfg_reg.ethertype_arp  <= ETHERTYPE_ARP_RST;
            cfg_reg.tcp_protocol   <= TCP_PROTOCOL_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_CONN_LIMIT:     cfg_reg.conn_limit     <= pwdata[4:0];
                REG_ETHERTYPE_IPV4: cfg_reg.ethertype_ipv4 <= pwdata[15:0];
                REG_ETHERTYPE_ARP:  cfg_reg.ethertype_arp  <= pwdata[15:0];
                REG_TCP_PROTOCOL:   cfg_reg.tcp_protocol   <= pwdata[7:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_CONN_LIMIT:     prdata = PDATA_W'(cfg_reg.conn_limit);
            REG_ETHERTYPE_IPV4: prdata = PDATA_W'(cfg_reg.ethertype_ipv4);
            REG_ETHERTYPE_ARP:  prdata = PDATA_W'(cfg_reg.ethertype_arp);
            REG_TCP_PROTOCOL:   prdata = PDATA_W'(cfg_reg.tcp_protocol);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- design/tcp_connection_tracker_core.sv -----
// ----------------------------------------------------------------------------
// TCP connection tracker core
// Classifies received frame headers and tracks TCP connections in an entry RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Word
//  frame     in         frame_valid/frame_stall   tct_pkg::frame_t
//  result    out        result_valid/result_stall tct_pkg::result_t
//  config    in         APB psel/penable/pwrite   four 32-bit registers
//
//  A frame that is not TCP passes the classify and emit states to the output register.
//  A TCP frame scans the filled entries one per cycle through the RAM read
//  port in the search state, up to the matching entry or, on a miss, through
//  every filled entry; an empty table skips the search.
//  Frames are accepted only in the idle state, once the last one has left emit.
//  Reset empties the table at once through the fill count; no clearing pass.
//  A stalled result waits in the output register while the next frame works.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_connection_tracker_core #(
    parameter int CONN_MAX = tct_pkg::CONN_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        frame_valid,
    output logic                        frame_stall,
    input  tct_pkg::frame_t             frame,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tct_pkg::result_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tct_pkg::PADDR_W-1:0] paddr,
    input  logic [tct_pkg::PDATA_W-1:0] pwdata,
    output logic [tct_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import tct_pkg::*;

    localparam int CNT_W = $clog2(CONN_MAX + 1);
    localparam int IDX_W = (CONN_MAX > 1) ? $clog2(CONN_MAX) : 1;
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    cfg_t             cfg;
    state_t           state_reg, state_next;
    frame_t           item_reg, item_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    result_t          res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_word_reg, out_word_next;

    entry_t           mem [CONN_MAX];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic is_arp, is_ipv4, is_tcp, hit, last_entry, table_full, out_free;

    tct_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign is_arp  = item_reg.ether_type == cfg.ethertype_arp;
    assign is_ipv4 = item_reg.ether_type == cfg.ethertype_ipv4;
    assign is_tcp  = (item_reg.ip_version == IP_VERSION4)
                     && (item_reg.ip_protocol == cfg.tcp_protocol);
    assign hit = (rd_data_reg.src_ip == item_reg.src_ip)
                 && (rd_data_reg.src_port == item_reg.src_port)
                 && (rd_data_reg.dst_ip == item_reg.dst_ip)
                 && (rd_data_reg.dst_port == item_reg.dst_port);
    assign last_entry = (CNT_W'(scan_reg) + CNT_W'(1)) >= fill_reg;
    assign table_full = (CMP_W'(fill_reg) >= CMP_W'(cfg.conn_limit))
                        || (fill_reg == CNT_W'(CONN_MAX));
    assign out_free   = !out_valid_reg || !result_stall;

    assign frame_stall  = state_reg != ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (is_arp || !is_ipv4 || !is_tcp || (fill_reg == '0))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (hit || last_entry)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        scan_next      = scan_reg;
        fill_next      = fill_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_word_next  = out_word_reg;
        rd_addr        = scan_reg;
        wr_en          = 1'b0;
        wr_addr        = scan_reg;
        wr_data        = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    item_next = frame;
                end
            end
            ST_CLASSIFY:
            begin
                res_next = '{action: ACT_DROP_ETHERTYPE, entry_index: '0,
                             seq_out: '0, ack_out: '0};
                rd_addr   = '0;
                scan_next = '0;
                priority if (is_arp)
                begin
                    res_next.action = (item_reg.arp_proto_type == cfg.ethertype_ipv4)
                                      ? ACT_ARP_REPLY : ACT_ARP_DROP;
                end
                else if (!is_ipv4)
                begin
                    res_next.action = ACT_DROP_ETHERTYPE;
                end
                else if (!is_tcp)
                begin
                    res_next.action = ACT_DROP_NOT_TCP;
                end
                else if (fill_reg == '0)
                begin
                    if (table_full)
                    begin
                        res_next.action = ACT_TABLE_FULL;
                    end
                    else
                    begin
                        res_next.action = ACT_SYN_ACK;
                        res_next.seq_out = item_reg.initial_seq;
                        res_next.ack_out = item_reg.peer_seq + 32'd1;
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data   = '{src_ip: item_reg.src_ip, src_port: item_reg.src_port,
                                      dst_ip: item_reg.dst_ip, dst_port: item_reg.dst_port,
                                      phase: PHASE_SYN_RECEIVED,
                                      seq: item_reg.initial_seq};
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
            end
            ST_SEARCH:
            begin
                res_next = '{action: ACT_IGNORE, entry_index: 4'(scan_reg),
                             seq_out: '0, ack_out: '0};
                if (hit)
                begin
                    unique case (rd_data_reg.phase)
                        PHASE_LISTEN:
                        begin
                            res_next.action  = ACT_SYN_ACK;
                            res_next.seq_out = rd_data_reg.seq;
                            res_next.ack_out = item_reg.peer_seq + 32'd1;
                            wr_en         = 1'b1;
                            wr_data.phase = PHASE_SYN_RECEIVED;
                        end
                        PHASE_SYN_RECEIVED:
                        begin
                            res_next.action  = ACT_SEND_DATA;
                            res_next.seq_out = rd_data_reg.seq;
                            wr_en         = 1'b1;
                            wr_data.phase = PHASE_ESTABLISHED;
                            wr_data.seq   = rd_data_reg.seq + 16'd1;
                        end
                        default:
                        begin
                            res_next.action = ACT_IGNORE;
                        end
                    endcase
                end
                else if (last_entry)
                begin
                    if (table_full)
                    begin
                        res_next.action      = ACT_TABLE_FULL;
                        res_next.entry_index = '0;
                    end
                    else
                    begin
                        res_next.action      = ACT_SYN_ACK;
                        res_next.entry_index = 4'(fill_reg);
                        res_next.seq_out     = item_reg.initial_seq;
                        res_next.ack_out     = item_reg.peer_seq + 32'd1;
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[IDX_W-1:0];
                        wr_data   = '{src_ip: item_reg.src_ip, src_port: item_reg.src_port,
                                      dst_ip: item_reg.dst_ip, dst_port: item_reg.dst_port,
                                      phase: PHASE_SYN_RECEIVED,
                                      seq: item_reg.initial_seq};
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    rd_addr   = scan_reg + IDX_W'(1);
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                end
            end
            default:
            begin
                item_next = item_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

endmodule

// ----- design/tct_checker.sv -----
// ----------------------------------------------------------------------------
// TCP connection tracker checker
// Port-level assertions on the connection tracker core, bound to the core module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_connection_tracker_core_macros.svh"

module tct_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             frame_valid,
    input logic             frame_stall,
    input tct_pkg::frame_t  frame,
    input logic             result_valid,
    input logic             result_stall,
    input tct_pkg::result_t result
);
    import tct_pkg::*;

    logic no_entry_action;

    assign no_entry_action = (result.action == ACT_DROP_ETHERTYPE)
                             || (result.action == ACT_ARP_REPLY)
                             || (result.action == ACT_ARP_DROP)
                             || (result.action == ACT_DROP_NOT_TCP)
                             || (result.action == ACT_TABLE_FULL);

    `TCT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
    `TCT_ASSERT_NEXT(a_one_frame, frame_valid && !frame_stall, frame_stall, "frame accepted while another is in work")
    `TCT_ASSERT_SAME(a_no_entry, result_valid && no_entry_action, (result.entry_index == 4'd0) && (result.seq_out == 16'd0) && (result.ack_out == 32'd0), "dropped frame carries entry data")
    `TCT_ASSERT_SAME(a_ack_only_synack, result_valid && (result.action != ACT_SYN_ACK), result.ack_out == 32'd0, "ack set on a result that is not a syn-ack")

endmodule

bind tcp_connection_tracker_core tct_checker u_tct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- tb/tct_result_checker.sv -----
// ----------------------------------------------------------------------------
// TCP connection tracker result checker
// Watches the configuration port and both word channels of the tracker core.
// It keeps its own copy of the registers and the connection table, predicts
// the result word for every accepted frame word, and compares each accepted
// result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tct_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        frame_valid,
    input  logic                        frame_stall,
    input  tct_pkg::frame_t             frame_word,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  tct_pkg::result_t            result_word,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [tct_pkg::PADDR_W-1:0] paddr,
    input  logic [tct_pkg::PDATA_W-1:0] pwdata,
    output int                          errors,
    output int                          outstanding
);

    import tct_pkg::*;

    localparam int TABLE_DEPTH = CONN_MAX_DEF;

    cfg_t    regs;
    int      fill;
    entry_t  conn_table [TABLE_DEPTH];
    result_t pending_replies [$];
    result_t oldest;
    int      fail_count;

    function automatic result_t next_reply(frame_t f);
        result_t r;
        int      slot;
        int      limit;
        bit      hit;
        r = '0;
        slot = 0;
        hit = 1'b0;
        limit = (regs.conn_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(regs.conn_limit);
        if (f.ether_type == regs.ethertype_arp)
        begin
            r.action = (f.arp_proto_type == regs.ethertype_ipv4) ? ACT_ARP_REPLY : ACT_ARP_DROP;
            return r;
        end
        if (f.ether_type != regs.ethertype_ipv4)
        begin
            r.action = ACT_DROP_ETHERTYPE;
            return r;
        end
        if (f.ip_version != IP_VERSION4 || f.ip_protocol != regs.tcp_protocol)
        begin
            r.action = ACT_DROP_NOT_TCP;
            return r;
        end
        for (int i = 0; i < fill && !hit; i++)
        begin
            if (conn_table[i].src_ip == f.src_ip && conn_table[i].src_port == f.src_port &&
                conn_table[i].dst_ip == f.dst_ip && conn_table[i].dst_port == f.dst_port)
            begin
                slot = i;
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            if (fill >= limit)
            begin
                r.action = ACT_TABLE_FULL;
                return r;
            end
            slot = fill;
            conn_table[slot].src_ip = f.src_ip;
            conn_table[slot].src_port = f.src_port;
            conn_table[slot].dst_ip = f.dst_ip;
            conn_table[slot].dst_port = f.dst_port;
            conn_table[slot].phase = PHASE_LISTEN;
            conn_table[slot].seq = f.initial_seq;
            fill++;
        end
        r.entry_index = 4'(slot);
        case (conn_table[slot].phase)
            PHASE_LISTEN:
            begin
                r.action = ACT_SYN_ACK;
                r.seq_out = conn_table[slot].seq;
                r.ack_out = f.peer_seq + 32'd1;
                conn_table[slot].phase = PHASE_SYN_RECEIVED;
            end
            PHASE_SYN_RECEIVED:
            begin
                r.action = ACT_SEND_DATA;
                r.seq_out = conn_table[slot].seq;
                conn_table[slot].seq = conn_table[slot].seq + 16'd1;
                conn_table[slot].phase = PHASE_ESTABLISHED;
            end
            default:
            begin
                r.action = ACT_IGNORE;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '{conn_limit: CONN_LIMIT_RST, ethertype_ipv4: ETHERTYPE_IPV4_RST,
                     ethertype_arp: ETHERTYPE_ARP_RST, tcp_protocol: TCP_PROTOCOL_RST};
            fill = 0;
            fail_count = 0;
            pending_replies.delete();
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_index_t'(paddr[PADDR_W-1:2]))
                    REG_CONN_LIMIT:     regs.conn_limit = pwdata[4:0];
                    REG_ETHERTYPE_IPV4: regs.ethertype_ipv4 = pwdata[15:0];
                    REG_ETHERTYPE_ARP:  regs.ethertype_arp = pwdata[15:0];
                    REG_TCP_PROTOCOL:   regs.tcp_protocol = pwdata[7:0];
                    default:            ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected none, actual %h",
                             $time, result_word);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_replies.pop_front();
                    check_field("action", 32'(oldest.action), 32'(result_word.action));
                    check_field("entry_index", 32'(oldest.entry_index),
                                32'(result_word.entry_index));
                    check_field("seq_out", 32'(oldest.seq_out), 32'(result_word.seq_out));
                    check_field("ack_out", oldest.ack_out, result_word.ack_out);
                end
            end
            if (frame_valid && !frame_stall)
            begin
                pending_replies.push_back(next_reply(frame_word));
            end
            outstanding <= pending_replies.size();
            errors <= fail_count;
        end
    end

endmodule

// ----- tb/tcp_connection_tracker_core_tb.sv -----
// ----------------------------------------------------------------------------
// TCP connection tracker core testbench
// Drives frame header words into the tracker core with random gaps and
// receiver stalls, including two long receiver hold-offs. A directed part
// covers the drop paths, ARP handling, table-full cases, sequence wrap and a
// shared ethertype; random phases under several register settings follow.
// A checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_connection_tracker_core_tb;

    import tct_pkg::*;

    localparam int POOL_SIZE      = 20;
    localparam int PHASE_WORDS    = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                clk;
    logic                rst_n;
    logic                frame_valid;
    logic                frame_stall;
    frame_t              frame_word;
    logic                result_valid;
    logic                result_stall;
    result_t             result_word;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  errors;
    int                  outstanding;
    int                  quiet_cycles;
    cfg_t                applied_cfg;
    frame_t              tuple_pool [POOL_SIZE];
    bit                  sender_calm;

    tcp_connection_tracker_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tct_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_word   (frame_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_frame(frame_t f);
        int gap;
        if ($urandom_range(15) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(18);
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_word <= f;
        do @(posedge clk); while (frame_stall);
    endtask

    task automatic settle();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (CONN_MAX_DEF + 8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CONN_LIMIT:     applied_cfg.conn_limit = value[4:0];
            REG_ETHERTYPE_IPV4: applied_cfg.ethertype_ipv4 = value[15:0];
            REG_ETHERTYPE_ARP:  applied_cfg.ethertype_arp = value[15:0];
            default:            applied_cfg.tcp_protocol = value[7:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(logic [4:0] limit, logic [15:0] ipv4, logic [15:0] arp,
                              logic [7:0] proto);
        write_reg(REG_CONN_LIMIT, 32'(limit));
        write_reg(REG_ETHERTYPE_IPV4, 32'(ipv4));
        write_reg(REG_ETHERTYPE_ARP, 32'(arp));
        write_reg(REG_TCP_PROTOCOL, 32'(proto));
    endtask

    function automatic frame_t tcp_frame(logic [31:0] sip, logic [15:0] sport,
                                         logic [31:0] dip, logic [15:0] dport,
                                         logic [31:0] pseq, logic [15:0] iseq);
        frame_t f;
        f.ether_type = applied_cfg.ethertype_ipv4;
        f.arp_proto_type = applied_cfg.ethertype_ipv4;
        f.ip_version = IP_VERSION4;
        f.ip_protocol = applied_cfg.tcp_protocol;
        f.src_ip = sip;
        f.src_port = sport;
        f.dst_ip = dip;
        f.dst_port = dport;
        f.peer_seq = pseq;
        f.initial_seq = iseq;
        return f;
    endfunction

    // Mostly well-formed TCP words on a small set of recurring connections,
    // so that entries walk through their phases; the rest is ARP, malformed
    // IPv4 and pure noise.
    function automatic frame_t make_frame();
        frame_t f;
        frame_t pick;
        int     kind;
        f.ether_type = 16'($urandom);
        f.arp_proto_type = 16'($urandom);
        f.ip_version = 4'($urandom);
        f.ip_protocol = 8'($urandom);
        f.src_ip = $urandom;
        f.src_port = 16'($urandom);
        f.dst_ip = $urandom;
        f.dst_port = 16'($urandom);
        f.peer_seq = $urandom;
        f.initial_seq = 16'($urandom);
        kind = $urandom_range(99);
        if (kind < 8)
            return f;
        f.ether_type = applied_cfg.ethertype_ipv4;
        f.ip_version = IP_VERSION4;
        f.ip_protocol = applied_cfg.tcp_protocol;
        if (kind < 18)
        begin
            f.ether_type = applied_cfg.ethertype_arp;
            if ($urandom_range(1) == 1)
                f.arp_proto_type = applied_cfg.ethertype_ipv4;
        end
        else if (kind < 24)
        begin
            if ($urandom_range(1) == 1)
                f.ip_version = 4'($urandom);
            else
                f.ip_protocol = 8'($urandom);
        end
        else if ($urandom_range(9) != 0)
        begin
            pick = tuple_pool[$urandom_range(POOL_SIZE - 1)];
            f.src_ip = pick.src_ip;
            f.src_port = pick.src_port;
            f.dst_ip = pick.dst_ip;
            f.dst_port = pick.dst_port;
        end
        return f;
    endfunction

    // The receiver holds off twice for a long stretch so that the core fills
    // up and stalls its frame input.
    initial
    begin
        int gap;
        int taken;
        bit calm;
        result_stall = 1'b1;
        taken = 0;
        calm = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (taken == 300 || taken == 800)
                gap = HOLD_CYCLES;
            else
            begin
                if ($urandom_range(15) == 0)
                    calm = !calm;
                gap = calm ? 0 : $urandom_range(18);
            end
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (result_valid && !result_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        frame_t f;
        rst_n = 1'b0;
        frame_valid = 1'b0;
        frame_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_cycles = 0;
        sender_calm = 1'b0;
        applied_cfg = '{conn_limit: CONN_LIMIT_RST, ethertype_ipv4: ETHERTYPE_IPV4_RST,
                        ethertype_arp: ETHERTYPE_ARP_RST, tcp_protocol: TCP_PROTOCOL_RST};
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tuple_pool[i] = '0;
            tuple_pool[i].src_ip = $urandom;
            tuple_pool[i].src_port = 16'($urandom);
            tuple_pool[i].dst_ip = $urandom;
            tuple_pool[i].dst_port = 16'($urandom);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        f = '0;
        f.ether_type = ETHERTYPE_ARP_RST;
        f.arp_proto_type = ETHERTYPE_IPV4_RST;
        send_frame(f);
        f.arp_proto_type = 16'hFFFF;
        send_frame(f);
        f = '1;
        send_frame(f);
        f = '0;
        send_frame(f);
        f.ether_type = ETHERTYPE_IPV4_RST;
        f.ip_version = 4'hF;
        f.ip_protocol = TCP_PROTOCOL_RST;
        send_frame(f);
        f.ip_version = IP_VERSION4;
        f.ip_protocol = 8'hFF;
        send_frame(f);

        // A limit of zero leaves no room for any connection.
        settle();
        write_reg(REG_CONN_LIMIT, 32'd0);
        send_frame(tcp_frame('0, '0, '0, '0, '1, '1));

        // One entry: full handshake with sequence wrap, then a full table.
        settle();
        write_reg(REG_CONN_LIMIT, 32'd1);
        repeat (3) send_frame(tcp_frame('0, '0, '0, '0, 32'hFFFF_FFFF, 16'hFFFF));
        send_frame(tcp_frame('1, '1, '1, '1, '0, '0));

        // The same ethertype in both registers is treated as ARP.
        settle();
        write_reg(REG_CONN_LIMIT, 32'd16);
        write_reg(REG_ETHERTYPE_ARP, 32'(ETHERTYPE_IPV4_RST));
        send_frame(tcp_frame(32'd1, 16'd2, 32'd3, 16'd4, 32'd5, 16'd6));

        settle();
        write_reg(REG_ETHERTYPE_ARP, 32'(ETHERTYPE_ARP_RST));
        repeat (2) send_frame(tcp_frame('1, '1, '1, '1, '0, '0));
        send_frame(tcp_frame('1, '1, '1, 16'hFFFE, 32'h8000_0000, 16'h8000));

        for (int p = 0; p < 5; p++)
        begin
            settle();
            case (p)
                0: set_config(5'd4, ETHERTYPE_IPV4_RST, ETHERTYPE_ARP_RST, TCP_PROTOCOL_RST);
                1: set_config(5'd31, 16'hFFFF, 16'h0000, 8'hFF);
                2: set_config(5'd16, 16'($urandom), 16'($urandom), 8'($urandom));
                3: set_config(5'd2, 16'h0000, 16'hFFFF, 8'h00);
                default: set_config(5'($urandom_range(16, 1)), 16'($urandom),
                                    16'($urandom), 8'($urandom));
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_frame(make_frame());
        end

        settle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
